// File: src/fcsg_pkg.sv
// Package for the filled circle span generator.
// Types, widths and constants shared by the controller, datapath and top level.
// No dependencies.
`default_nettype none

package fcsg_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_RADIUS = 63;
    localparam int DEF_COORD_BITS = 12;

    // Fixed widths and limits
    localparam int RADIUS_BITS = 6;
    localparam int MAX_RESULTS = 48;
    localparam int CNT_BITS    = $clog2(MAX_RESULTS + 1);

    // Midpoint recurrence constants
    localparam int D_INIT = 3;   // decision = 3 - 2r
    localparam int D_DIAG = 10;  // step with y decrement
    localparam int D_SIDE = 6;   // step with y held

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } fcsg_state_t;

    // Controller -> datapath
    typedef struct packed {
        logic load;   // capture request, start a circle
        logic emit;   // write output register, advance the point
    } fcsg_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic last;   // current point is the final one of this circle
    } fcsg_sts_t;

endpackage

`default_nettype wire

// File: src/fcsg_ctrl.sv
// Controller for the filled circle span generator.
// Sequences request capture and span emission, owns the output valid flag.
// Depends on fcsg_pkg.
`default_nettype none

module fcsg_ctrl
    import fcsg_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_stall,
    output logic           span_valid,
    input  wire logic      span_stall,
    output fcsg_cmd_t      cmd,
    input  wire fcsg_sts_t sts
);

    fcsg_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;

    // State and output valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_stall  = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                // emit when the output register is empty or being drained
                if (!out_valid_reg || !span_stall)
                begin
                    cmd.emit = 1'b1;
                    if (sts.last)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register occupancy
    always_comb
    begin
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (!span_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign span_valid = out_valid_reg;

endmodule

`default_nettype wire

// File: src/fcsg_dp.sv
// Datapath for the filled circle span generator.
// Holds the midpoint recurrence point, result count and the output span register.
// Depends on fcsg_pkg.
`default_nettype none

module fcsg_dp
    import fcsg_pkg::*;
#(
    parameter int MAX_RADIUS = DEF_MAX_RADIUS,
    parameter int COORD_BITS = DEF_COORD_BITS
)
(
    input  wire logic                          clk,
    input  wire logic [COORD_BITS-1:0]         circle_x,
    input  wire logic [COORD_BITS-1:0]         circle_y,
    input  wire logic [RADIUS_BITS-1:0]        radius,
    input  wire fcsg_cmd_t                     cmd,
    output fcsg_sts_t                          sts,
    output logic signed [COORD_BITS+1:0]       near_right_x,
    output logic signed [COORD_BITS+1:0]       near_left_x,
    output logic signed [COORD_BITS+1:0]       far_row_below,
    output logic signed [COORD_BITS+1:0]       far_row_above,
    output logic signed [COORD_BITS+1:0]       wide_right_x,
    output logic signed [COORD_BITS+1:0]       wide_left_x,
    output logic signed [COORD_BITS+1:0]       near_row_below,
    output logic signed [COORD_BITS+1:0]       near_row_above,
    output logic                               last
);

    localparam int OUT_BITS  = COORD_BITS + 2;
    localparam int STEP_BITS = $clog2(MAX_RADIUS + 1) + 2;
    localparam int DEC_BITS  = STEP_BITS + 4;

    // Recurrence point and request registers
    logic        [COORD_BITS-1:0] cx_reg, cy_reg;
    logic signed [STEP_BITS-1:0]  x_reg, x_next;
    logic signed [STEP_BITS-1:0]  y_reg, y_next;
    logic signed [DEC_BITS-1:0]   d_reg, d_next;
    logic        [CNT_BITS-1:0]   n_reg;

    // Output span registers
    logic signed [OUT_BITS-1:0] nrx_reg, nlx_reg, fyb_reg, fya_reg;
    logic signed [OUT_BITS-1:0] wrx_reg, wlx_reg, nyb_reg, nya_reg;
    logic                       last_reg;

    logic signed [STEP_BITS-1:0] r_sat;
    logic signed [STEP_BITS-1:0] x_inc, y_dec;
    logic signed [DEC_BITS-1:0]  diff;
    logic                        is_last;

    // Radius saturation
    always_comb
    begin
        if ({{(32-RADIUS_BITS){1'b0}}, radius} > MAX_RADIUS)
            r_sat = STEP_BITS'(MAX_RADIUS);
        else
            r_sat = STEP_BITS'(radius);
    end

    // One midpoint step
    always_comb
    begin
        x_inc = x_reg + STEP_BITS'(1);
        y_dec = y_reg - STEP_BITS'(1);
        x_next = x_inc;
        if (d_reg > 0)
        begin
            y_next = y_dec;
            diff   = DEC_BITS'(x_inc) - DEC_BITS'(y_dec);
            d_next = d_reg + (diff <<< 2) + DEC_BITS'(D_DIAG);
        end
        else
        begin
            y_next = y_reg;
            diff   = DEC_BITS'(x_inc);
            d_next = d_reg + (diff <<< 2) + DEC_BITS'(D_SIDE);
        end
    end

    // Last when the loop test fails after this point
    assign is_last  = !((y_reg >= x_reg) && (n_reg < CNT_BITS'(MAX_RESULTS - 1)));
    assign sts.last = is_last;

    // Point, count and center
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cx_reg <= circle_x;
            cy_reg <= circle_y;
            x_reg  <= '0;
            y_reg  <= r_sat;
            d_reg  <= DEC_BITS'(D_INIT) - (DEC_BITS'(r_sat) <<< 1);
            n_reg  <= '0;
        end
        else if (cmd.emit)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            d_reg <= d_next;
            n_reg <= n_reg + CNT_BITS'(1);
        end
    end

    // Span output register
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            nrx_reg  <= OUT_BITS'(cx_reg) + OUT_BITS'(x_reg);
            nlx_reg  <= OUT_BITS'(cx_reg) - OUT_BITS'(x_reg);
            fyb_reg  <= OUT_BITS'(cy_reg) + OUT_BITS'(y_reg);
            fya_reg  <= OUT_BITS'(cy_reg) - OUT_BITS'(y_reg);
            wrx_reg  <= OUT_BITS'(cx_reg) + OUT_BITS'(y_reg);
            wlx_reg  <= OUT_BITS'(cx_reg) - OUT_BITS'(y_reg);
            nyb_reg  <= OUT_BITS'(cy_reg) + OUT_BITS'(x_reg);
            nya_reg  <= OUT_BITS'(cy_reg) - OUT_BITS'(x_reg);
            last_reg <= is_last;
        end
    end

    assign near_right_x   = nrx_reg;
    assign near_left_x    = nlx_reg;
    assign far_row_below  = fyb_reg;
    assign far_row_above  = fya_reg;
    assign wide_right_x   = wrx_reg;
    assign wide_left_x    = wlx_reg;
    assign near_row_below = nyb_reg;
    assign near_row_above = nya_reg;
    assign last           = last_reg;

endmodule

`default_nettype wire

// File: src/filled_circle_span_generator.sv
// Filled circle span generator (midpoint circle fill).
//
// Request channel (req_valid / req_stall): circle_x, circle_y, radius. A
// request is taken when req_valid is high and req_stall low; req_stall is
// low whenever no circle is in progress, even while the final span item
// still waits in the output register.
// Span channel (span_valid / span_stall): eight span coordinates and last.
// One item for the start point, then one per midpoint step until y < x,
// capped at 48 items; last marks the final item of the circle. A radius
// above MAX_RADIUS is clamped to it.
// The first item is registered in the output register once the request is taken
// and the start point loaded, then one item per cycle while span_stall is low;
// the recurrence unit computes a single midpoint step per item.
// span_stall holds the output register and freezes the recurrence; no item
// is lost. Reset (rst_n, asynchronous) returns to idle with no valid output.
// Depends on fcsg_pkg, fcsg_ctrl, fcsg_dp.
`default_nettype none

module filled_circle_span_generator
    import fcsg_pkg::*;
#(
    parameter int MAX_RADIUS = DEF_MAX_RADIUS,
    parameter int COORD_BITS = DEF_COORD_BITS
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    req_valid,
    output logic                         req_stall,
    input  wire logic [COORD_BITS-1:0]   circle_x,
    input  wire logic [COORD_BITS-1:0]   circle_y,
    input  wire logic [RADIUS_BITS-1:0]  radius,
    output logic                         span_valid,
    input  wire logic                    span_stall,
    output logic signed [COORD_BITS+1:0] near_right_x,
    output logic signed [COORD_BITS+1:0] near_left_x,
    output logic signed [COORD_BITS+1:0] far_row_below,
    output logic signed [COORD_BITS+1:0] far_row_above,
    output logic signed [COORD_BITS+1:0] wide_right_x,
    output logic signed [COORD_BITS+1:0] wide_left_x,
    output logic signed [COORD_BITS+1:0] near_row_below,
    output logic signed [COORD_BITS+1:0] near_row_above,
    output logic                         last
);

    fcsg_cmd_t cmd;
    fcsg_sts_t sts;

    // Sequencer
    fcsg_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .span_valid (span_valid),
        .span_stall (span_stall),
        .cmd        (cmd),
        .sts        (sts)
    );

    // Recurrence and span registers
    fcsg_dp #(
        .MAX_RADIUS (MAX_RADIUS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .clk            (clk),
        .circle_x       (circle_x),
        .circle_y       (circle_y),
        .radius         (radius),
        .cmd            (cmd),
        .sts            (sts),
        .near_right_x   (near_right_x),
        .near_left_x    (near_left_x),
        .far_row_below  (far_row_below),
        .far_row_above  (far_row_above),
        .wide_right_x   (wide_right_x),
        .wide_left_x    (wide_left_x),
        .near_row_below (near_row_below),
        .near_row_above (near_row_above),
        .last           (last)
    );

endmodule

`default_nettype wire

// File: sim/filled_circle_span_generator_test.sv
`timescale 1ns / 1ps
// Testbench for filled_circle_span_generator: drives circle requests, predicts
// the midpoint fill spans and checks every span item against the prediction.
// Depends on fcsg_pkg and the filled_circle_span_generator RTL.

module filled_circle_span_generator_test;
    import fcsg_pkg::*;

    localparam int MAX_RADIUS = DEF_MAX_RADIUS;
    localparam int COORD_BITS = DEF_COORD_BITS;
    localparam int SPAN_BITS  = COORD_BITS + 2;
    localparam int RAND_ITEMS = 450;
    localparam int LONG_HOLD  = 400;
    localparam int TAIL_WAIT  = 20;

    // One span item as it leaves the block, in port order
    typedef struct packed {
        logic [SPAN_BITS-1:0] near_right_x;
        logic [SPAN_BITS-1:0] near_left_x;
        logic [SPAN_BITS-1:0] far_row_below;
        logic [SPAN_BITS-1:0] far_row_above;
        logic [SPAN_BITS-1:0] wide_right_x;
        logic [SPAN_BITS-1:0] wide_left_x;
        logic [SPAN_BITS-1:0] near_row_below;
        logic [SPAN_BITS-1:0] near_row_above;
        logic                 last;
    } span_item_t;

    // Circle predictor and span checker
    class circle_span_checker;
        span_item_t expected_spans[$];
        int mismatches = 0;
        int spans_seen = 0;
        int pos_x = 0;
        int pos_y = 0;
        int decision = 0;
        int held_cx = 0;
        int held_cy = 0;

        function span_item_t span_at_point();
            span_item_t s;
            s.near_right_x   = SPAN_BITS'(held_cx + pos_x);
            s.near_left_x    = SPAN_BITS'(held_cx - pos_x);
            s.far_row_below  = SPAN_BITS'(held_cy + pos_y);
            s.far_row_above  = SPAN_BITS'(held_cy - pos_y);
            s.wide_right_x   = SPAN_BITS'(held_cx + pos_y);
            s.wide_left_x    = SPAN_BITS'(held_cx - pos_y);
            s.near_row_below = SPAN_BITS'(held_cy + pos_x);
            s.near_row_above = SPAN_BITS'(held_cy - pos_x);
            s.last           = 1'b0;
            return s;
        endfunction

        // Accepted request: run the whole circle and queue its spans
        function void note_request(logic [COORD_BITS-1:0] cx, logic [COORD_BITS-1:0] cy,
                                   logic [RADIUS_BITS-1:0] r);
            span_item_t s;
            int rad;
            int count;
            bit done;
            rad = int'(r);
            if (rad > MAX_RADIUS)
                rad = MAX_RADIUS;
            held_cx  = int'(cx);
            held_cy  = int'(cy);
            pos_x    = 0;
            pos_y    = rad;
            decision = D_INIT - 2 * rad;
            count    = 0;
            done     = 1'b0;
            while (!done)
            begin
                s = span_at_point();
                count++;
                // last when the loop has crossed or the item cap is hit
                s.last = !(pos_y >= pos_x && count < MAX_RESULTS);
                expected_spans.push_back(s);
                done = s.last;
                if (!done)
                begin
                    pos_x++;
                    if (decision > 0)
                    begin
                        pos_y--;
                        decision = decision + 4 * (pos_x - pos_y) + D_DIAG;
                    end
                    else
                    begin
                        decision = decision + 4 * pos_x + D_SIDE;
                    end
                end
            end
        endfunction

        function void compare_field(string field, logic [SPAN_BITS-1:0] want,
                                    logic [SPAN_BITS-1:0] got);
            if (want !== got)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("span %0d %s: expected %h, got %h", spans_seen, field, want, got);
            end
        endfunction

        // Accepted span item: compare with the oldest expectation
        function void check_span(span_item_t got);
            span_item_t want;
            if (expected_spans.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("span %0d: item with none expected, got %h", spans_seen, got);
            end
            else
            begin
                want = expected_spans.pop_front();
                compare_field("near_right_x", want.near_right_x, got.near_right_x);
                compare_field("near_left_x", want.near_left_x, got.near_left_x);
                compare_field("far_row_below", want.far_row_below, got.far_row_below);
                compare_field("far_row_above", want.far_row_above, got.far_row_above);
                compare_field("wide_right_x", want.wide_right_x, got.wide_right_x);
                compare_field("wide_left_x", want.wide_left_x, got.wide_left_x);
                compare_field("near_row_below", want.near_row_below, got.near_row_below);
                compare_field("near_row_above", want.near_row_above, got.near_row_above);
                compare_field("last", SPAN_BITS'(want.last), SPAN_BITS'(got.last));
            end
            spans_seen++;
        endfunction

        function int pending();
            return expected_spans.size();
        endfunction
    endclass

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          req_valid;
    logic                          req_stall;
    logic [COORD_BITS-1:0]         circle_x;
    logic [COORD_BITS-1:0]         circle_y;
    logic [RADIUS_BITS-1:0]        radius;
    logic                          span_valid;
    logic                          span_stall;
    logic signed [COORD_BITS+1:0]  near_right_x;
    logic signed [COORD_BITS+1:0]  near_left_x;
    logic signed [COORD_BITS+1:0]  far_row_below;
    logic signed [COORD_BITS+1:0]  far_row_above;
    logic signed [COORD_BITS+1:0]  wide_right_x;
    logic signed [COORD_BITS+1:0]  wide_left_x;
    logic signed [COORD_BITS+1:0]  near_row_below;
    logic signed [COORD_BITS+1:0]  near_row_above;
    logic                          last;

    bit quiet = 1'b0;            // no idling on either side
    bit hold_off_request = 1'b0; // ask the receiver for one long hold-off

    circle_span_checker checker_sb = new;

    filled_circle_span_generator #(
        .MAX_RADIUS (MAX_RADIUS),
        .COORD_BITS (COORD_BITS)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .circle_x       (circle_x),
        .circle_y       (circle_y),
        .radius         (radius),
        .span_valid     (span_valid),
        .span_stall     (span_stall),
        .near_right_x   (near_right_x),
        .near_left_x    (near_left_x),
        .far_row_below  (far_row_below),
        .far_row_above  (far_row_above),
        .wide_right_x   (wide_right_x),
        .wide_left_x    (wide_left_x),
        .near_row_below (near_row_below),
        .near_row_above (near_row_above),
        .last           (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Handshake monitor: values seen here are the ones before the edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                checker_sb.note_request(circle_x, circle_y, radius);
            if (span_valid && !span_stall)
                checker_sb.check_span({near_right_x, near_left_x, far_row_below,
                                       far_row_above, wide_right_x, wide_left_x,
                                       near_row_below, near_row_above, last});
        end
    end

    // Span receiver: random stall bursts, one long hold-off on request
    initial
    begin
        span_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_off_request)
            begin
                span_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                hold_off_request = 1'b0;
            end
            else if (quiet || $urandom_range(0, 2) != 0)
            begin
                span_stall <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            else
            begin
                span_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
        end
    end

    // Offer one request and hold it until taken, then idle for gap cycles
    task automatic send_request(input logic [COORD_BITS-1:0] cx,
                                input logic [COORD_BITS-1:0] cy,
                                input logic [RADIUS_BITS-1:0] r, input int gap);
        req_valid <= 1'b1;
        circle_x  <= cx;
        circle_y  <= cy;
        radius    <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        if (gap > 0)
        begin
            // junk payload while idle
            req_valid <= 1'b0;
            circle_x  <= COORD_BITS'($urandom);
            circle_y  <= COORD_BITS'($urandom);
            radius    <= RADIUS_BITS'($urandom);
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic int idle_gap();
        if (quiet || $urandom_range(0, 3) != 0)
            return 0;
        return $urandom_range(1, 15);
    endfunction

    function automatic logic [COORD_BITS-1:0] pick_coord();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return COORD_BITS'($urandom_range(0, (1 << COORD_BITS) - 1));
        endcase
    endfunction

    task automatic wait_for_spans();
        while (checker_sb.pending() != 0)
            @(posedge clk);
    endtask

    // Stimulus
    initial
    begin
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        circle_x  <= '0;
        circle_y  <= '0;
        radius    <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero radius at the origin gives y below zero and negative spans
        send_request(12'd0, 12'd0, 6'd0, idle_gap());
        send_request(12'd4095, 12'd4095, 6'd63, idle_gap());
        send_request(12'd0, 12'd4095, 6'd63, idle_gap());
        send_request(12'd4095, 12'd0, 6'd63, idle_gap());
        send_request(12'd0, 12'd0, 6'd63, idle_gap());
        send_request(12'd4095, 12'd4095, 6'd0, idle_gap());
        send_request(12'd2048, 12'd2048, 6'd0, idle_gap());
        send_request(12'd2048, 12'd2048, 6'd1, idle_gap());
        send_request(12'd2048, 12'd2048, 6'd2, idle_gap());
        send_request(12'd2048, 12'd2048, 6'd3, idle_gap());
        send_request(12'd100, 12'd200, 6'd62, idle_gap());
        send_request(12'hAAA, 12'h555, 6'h2A, idle_gap());
        send_request(12'h555, 12'hAAA, 6'h15, idle_gap());
        send_request(12'd63, 12'd63, 6'd63, idle_gap());
        send_request(12'd4032, 12'd4032, 6'd63, idle_gap());
        send_request(12'd1, 12'd1, 6'd1, idle_gap());
        send_request(12'd0, 12'd0, 6'd1, idle_gap());
        // back to back, no gaps
        send_request(12'd10, 12'd20, 6'd5, 0);
        send_request(12'd30, 12'd40, 6'd0, 0);
        send_request(12'd50, 12'd60, 6'd63, 0);

        // Random circles
        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            if (i == 150)
                hold_off_request = 1'b1;
            if (i == RAND_ITEMS - 60)
                quiet = 1'b1;
            if (i == 300)
            begin
                // sender pauses until the block has drained
                send_request(pick_coord(), pick_coord(),
                             RADIUS_BITS'($urandom_range(0, 63)), 1);
                wait_for_spans();
            end
            else
            begin
                send_request(pick_coord(), pick_coord(),
                             ($urandom_range(0, 7) == 0) ? RADIUS_BITS'(MAX_RADIUS)
                                 : RADIUS_BITS'($urandom_range(0, 63)),
                             idle_gap());
            end
        end
        req_valid <= 1'b0;

        wait_for_spans();
        repeat (TAIL_WAIT) @(posedge clk);
        if (checker_sb.mismatches == 0 && checker_sb.pending() == 0)
            $display("filled_circle_span_generator test passed");
        else
            $display("filled_circle_span_generator test failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #20_000_000;
        $display("filled_circle_span_generator test failed");
        $finish;
    end

endmodule
